// File: rtl/stable_sorted_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stable sorted priority queue
// Shared property wrappers used by the queue RTL
// ----------------------------------------------------------------------------
`ifndef STABLE_SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SSPQ_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define SSPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg
// Types and codes shared by the sorted priority queue and its cells
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sspq_pkg;

   localparam int TAG_W    = 8;
   localparam int KEY_W    = 16;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_DEQUEUE = 2'd1,
      OP_QUERY   = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [KEY_W-1:0] key;
   } entry_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

// File: rtl/sspq_cell.sv
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted queue: holds an entry, compares it with the
// incoming key and takes its own, the new, or a neighbor's entry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sspq_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                    clock,
   input  sspq_pkg::cell_ctrl_type ctrl,
   input  logic [CNT_W-1:0]        count,
   input  logic                    prev_ge,
   input  sspq_pkg::entry_type     prev_entry,
   input  sspq_pkg::entry_type     next_entry,
   output sspq_pkg::entry_type     entry,
   output sspq_pkg::entry_type     entry_next,
   output logic                    ge
);
   import sspq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      occupied;

   // slot holds a live entry when it sits below the fill level
   assign occupied = (count > CNT_W'(INDEX));

   // live entry that stays ahead of the incoming key
   assign ge = occupied && (entry_ff.key >= ctrl.new_entry.key);

   // choose what this slot holds after the transaction
   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.enq) begin
         if (!ge) begin
            entry_in = prev_ge ? ctrl.new_entry : prev_entry;
         end
      end else if (ctrl.deq) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

// File: rtl/stable_sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded priority queue kept in descending key order in a row of cells
// ----------------------------------------------------------------------------
// Each request transaction (enqueue, dequeue or query) produces one response
// transaction in the cycle after it is accepted, and a new request is taken in
// every cycle while the response side keeps up, so the sustained rate is one
// transaction per cycle. That figure is set by the cell row: the new key is
// broadcast to all QUEUE_DEPTH cells, each compares it with its own entry
// and the whole row shifts together in one step. Equal keys leave in arrival
// order. An enqueue on a full queue is dropped and a dequeue on an empty
// queue is ignored; both are flagged in rsp_status. Only the response
// register stalls the request side: req_stall follows rsp_stall while a
// response is pending. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stable_sorted_priority_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [sspq_pkg::OP_W-1:0]         req_operation,
   input  logic [sspq_pkg::TAG_W-1:0]        req_item_tag,
   input  logic [sspq_pkg::KEY_W-1:0]        req_priority_key,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [sspq_pkg::TAG_W-1:0]        rsp_head_tag,
   output logic [sspq_pkg::KEY_W-1:0]        rsp_head_key,
   output logic [sspq_pkg::COUNT_W-1:0]      rsp_entry_count,
   output logic                              rsp_is_empty,
   output logic [sspq_pkg::STATUS_W-1:0]     rsp_status
);
   import sspq_pkg::*;

   `include "stable_sorted_priority_queue_assert.svh"

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                 req_accept;
   op_type               op;
   cell_ctrl_type        ctrl;
   logic                 full;
   logic                 empty;
   status_type           status_in;

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [CNT_W+COUNT_W-1:0] count_ext;

   entry_type            cell_entry [QUEUE_DEPTH];
   entry_type            cell_next  [QUEUE_DEPTH];
   logic                 cell_ge    [QUEUE_DEPTH];

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [TAG_W-1:0]     rsp_head_tag_ff;
   logic [TAG_W-1:0]     rsp_head_tag_in;
   logic [KEY_W-1:0]     rsp_head_key_ff;
   logic [KEY_W-1:0]     rsp_head_key_in;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic [COUNT_W-1:0]   rsp_count_in;
   logic                 rsp_empty_ff;
   logic                 rsp_empty_in;
   status_type           rsp_status_ff;

   logic                 enq_drop;
   logic                 deq_take;
   logic                 head_ordered;

   // handshake: hold requests only while a response waits
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign op    = op_type'(req_operation);
   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);

   // decode the operation into cell controls and status
   always_comb begin
      ctrl.enq           = 1'b0;
      ctrl.deq           = 1'b0;
      ctrl.new_entry.tag = req_item_tag;
      ctrl.new_entry.key = req_priority_key;
      status_in          = ST_OK;
      count_in           = count_ff;
      unique case (op)
         OP_ENQUEUE: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               ctrl.enq = req_accept;
               count_in = count_ff + 1'b1;
            end
         end
         OP_DEQUEUE: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               ctrl.deq = req_accept;
               count_in = count_ff - 1'b1;
            end
         end
         OP_QUERY: begin
            status_in = ST_OK;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // row of cells, head at index zero
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic      prev_ge;
      entry_type prev_entry;
      entry_type next_entry;

      if (i == 0) begin : g_head
         assign prev_ge    = 1'b1;
         assign prev_entry = ctrl.new_entry;
      end else begin : g_body
         assign prev_ge    = cell_ge[i-1];
         assign prev_entry = cell_entry[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_entry = cell_entry[i];
      end else begin : g_inner
         assign next_entry = cell_entry[i+1];
      end

      sspq_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .prev_ge    (prev_ge),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (cell_entry[i]),
         .entry_next (cell_next[i]),
         .ge         (cell_ge[i])
      );
   end

   // fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req_accept) begin
         count_ff <= count_in;
      end
   end

   // response contents describe the queue after the transaction
   assign count_ext = {{COUNT_W{1'b0}}, count_in};

   always_comb begin
      rsp_count_in = count_ext[COUNT_W-1:0];
      rsp_empty_in = (count_in == '0);
      if (rsp_empty_in) begin
         rsp_head_tag_in = '0;
         rsp_head_key_in = '0;
      end else begin
         rsp_head_tag_in = cell_next[0].tag;
         rsp_head_key_in = cell_next[0].key;
      end
   end

   // response valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_head_tag_ff <= rsp_head_tag_in;
         rsp_head_key_ff <= rsp_head_key_in;
         rsp_count_ff    <= rsp_count_in;
         rsp_empty_ff    <= rsp_empty_in;
         rsp_status_ff   <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_head_tag    = rsp_head_tag_ff;
   assign rsp_head_key    = rsp_head_key_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_status      = rsp_status_ff;

   // checks
   assign enq_drop     = req_accept && (op == OP_ENQUEUE) && full;
   assign deq_take     = req_accept && (op == OP_DEQUEUE) && !empty;
   assign head_ordered = (cell_entry[0].key >= cell_entry[1].key);

   `SSPQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "fill level over depth")
   `SSPQ_ASSERT_NEXT(a_full_drop, enq_drop, rsp_status_ff == ST_FULL && $stable(count_ff), "bad drop")
   `SSPQ_ASSERT_NEXT(a_deq_count, deq_take, count_ff == $past(count_ff) - 1'b1, "count not reduced")
   `SSPQ_ASSERT_NOW(a_empty_flag, rsp_valid_ff, rsp_empty_ff == (count_ff == '0), "empty flag wrong")
   `SSPQ_ASSERT_NOW(a_head_order, count_ff >= CNT_W'(2), head_ordered, "head not the largest key")

endmodule
